/* rtl/vwcd_pkg.sv */
// vwcd_pkg: shared types, phase codes and zigzag table for the coefficient decoder
// no dependencies
package vwcd_pkg;

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_DCVAL  = 2'd1;
    localparam logic [1:0] PH_AC     = 2'd2;

    localparam logic [1:0] CFG_QLOW    = 2'd0;
    localparam logic [1:0] CFG_QHIGH   = 2'd1;
    localparam logic [1:0] CFG_DIVISOR = 2'd2;

    localparam logic [7:0] DIVISOR_RESET = 8'd4;

    localparam logic [5:0] ZZ_TO_RASTER [64] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

    typedef struct packed {
        logic signed [15:0] value;
        logic [5:0]         pos;
        logic [1:0]         comp;
        logic [8:0]         blk;
        logic               done;
        logic               sdone;
    } coef_rec_t;

    typedef struct packed {
        logic load;
        logic step;
        logic div_start;
        logic finish;
        logic final_end;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic pending;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/vwcd_div.sv */
// vwcd_div: restoring divider, one quotient bit per cycle
// 9-bit numerator by 8-bit divisor, no package dependencies
module vwcd_div
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [8:0] num,
    input  logic [7:0] den,
    output logic       done,
    output logic [8:0] quo
);

    logic [7:0] rem_reg, rem_next;
    logic [8:0] quo_reg, quo_next;
    logic [7:0] den_reg;
    logic [3:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [8:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[8]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 8'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[7:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[7:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd8)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/vwcd_dp.sv */
// vwcd_dp: decode state, bit parser, dc predictors, config registers and result registers
// depends on vwcd_pkg and vwcd_div
module vwcd_dp
    import vwcd_pkg::*;
#(
    parameter int MACRO_ROWS = 9,
    parameter int MACRO_COLS = 8,
    parameter int DC_WIDTH   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [7:0]  data_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        out_stall,
    output logic        out_valid,
    output coef_rec_t   out_rec
);

    localparam int TOTAL = MACRO_ROWS * MACRO_COLS * 6;
    localparam int BLK_W = $clog2(TOTAL + 1);

    logic [63:0] qlow_reg, qhigh_reg;
    logic [7:0]  div_reg;
    logic [7:0]  byte_reg;

    logic [1:0]          phase_reg, phase_next;
    logic [2:0]          prefix_reg, prefix_next;
    logic [7:0]          accum_reg, accum_next;
    logic [3:0]          left_reg, left_next;
    logic [3:0]          width_reg, width_next;
    logic [5:0]          zz_reg, zz_next;
    logic [2:0]          bim_reg, bim_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [DC_WIDTH-1:0] dcy_reg, dcy_next, dcb_reg, dcb_next, dcr_reg, dcr_next;
    logic                fin_reg, fin_next;

    coef_rec_t hold_reg, outr_reg, em_rec, close_rec;
    logic      hv_reg, ov_reg, em;

    logic                bit_in;
    logic [7:0]          acc_n, fmask, v8;
    logic [3:0]          bl;
    logic                sz_fire, dc_fire, neg;
    logic [3:0]          sz;
    logic signed [9:0]   diff;
    logic [DC_WIDTH-1:0] dc_sel, dc_new;
    logic [31:0]         dc_z;
    logic [1:0]          comp;
    logic [5:0]          rpos;
    logic [3:0]          qi;
    logic [7:0]          qent;
    logic [8:0]          dquo;
    logic                ddone;
    logic [3:0]          wsel;
    logic                out_free;

    assign bit_in = byte_reg[7];
    assign acc_n  = {accum_reg[6:0], bit_in};
    assign fmask  = 8'hFF >> (4'd8 - width_reg);
    assign v8     = acc_n & fmask;
    assign neg    = |(v8 & ~(fmask >> 1));
    assign comp   = (bim_reg < 3'd4) ? 2'd0 : ((bim_reg == 3'd4) ? 2'd1 : 2'd2);
    assign rpos   = ZZ_TO_RASTER[zz_reg];
    assign qi     = {rpos[5:4], rpos[2:1]};
    assign qent   = qi[3] ? qhigh_reg[{qi[2:0], 3'b000} +: 8] : qlow_reg[{qi[2:0], 3'b000} +: 8];
    assign out_free = !ov_reg || !out_stall;

    vwcd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({1'b0, qent} + {2'b00, div_reg[7:1]}),
        .den   (div_reg),
        .done  (ddone),
        .quo   (dquo)
    );

    always_comb
    begin
        if (div_reg == 8'd0 || dquo > 9'd8)
        begin
            wsel = 4'd8;
        end
        else if (dquo == 9'd0)
        begin
            wsel = 4'd1;
        end
        else
        begin
            wsel = dquo[3:0];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        width_next  = width_reg;
        zz_next     = zz_reg;
        bim_next    = bim_reg;
        blk_next    = blk_reg;
        dcy_next    = dcy_reg;
        dcb_next    = dcb_reg;
        dcr_next    = dcr_reg;
        fin_next    = fin_reg;
        em          = 1'b0;
        em_rec      = '0;
        sz_fire     = 1'b0;
        sz          = '0;
        dc_fire     = 1'b0;
        diff        = '0;
        bl          = (left_reg == 4'd0) ? 4'd0 : left_reg - 4'd1;
        dc_sel      = (bim_reg < 3'd4) ? dcy_reg : ((bim_reg == 3'd4) ? dcb_reg : dcr_reg);
        dc_new      = dc_sel;
        dc_z        = '0;

        if (ddone)
        begin
            width_next = wsel;
            left_next  = wsel;
            accum_next = '0;
        end

        if (cmd.step && !fin_reg)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    unique case (prefix_reg)
                        3'd0: prefix_next = bit_in ? 3'd2 : 3'd1;
                        3'd1:
                        begin
                            sz_fire = 1'b1;
                            sz      = bit_in ? 4'd2 : 4'd1;
                        end
                        3'd2: prefix_next = bit_in ? 3'd4 : 3'd3;
                        3'd3:
                        begin
                            sz_fire = 1'b1;
                            sz      = bit_in ? 4'd3 : 4'd0;
                        end
                        3'd4, 3'd5, 3'd6:
                        begin
                            if (bit_in)
                            begin
                                prefix_next = prefix_reg + 3'd1;
                            end
                            else
                            begin
                                sz_fire = 1'b1;
                                sz      = {1'b0, prefix_reg};
                            end
                        end
                        default:
                        begin
                            sz_fire = 1'b1;
                            sz      = bit_in ? 4'd8 : 4'd7;
                        end
                    endcase
                    if (sz_fire)
                    begin
                        prefix_next = '0;
                        if (sz == 4'd0)
                        begin
                            dc_fire = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DCVAL;
                            left_next  = sz;
                            width_next = sz;
                            accum_next = '0;
                        end
                    end
                end
                PH_DCVAL:
                begin
                    accum_next = acc_n;
                    left_next  = bl;
                    if (bl == 4'd0)
                    begin
                        dc_fire = 1'b1;
                        if (!neg)
                        begin
                            diff = $signed({2'b00, v8}) - $signed(10'(10'd1 << width_reg)) + 10'sd1;
                        end
                        else
                        begin
                            diff = $signed({2'b00, v8});
                        end
                    end
                end
                PH_AC:
                begin
                    accum_next = acc_n;
                    left_next  = bl;
                    if (bl == 4'd0)
                    begin
                        em           = 1'b1;
                        em_rec.value = {{8{neg}}, v8 | (neg ? ~fmask : 8'h00)};
                        em_rec.pos   = rpos;
                        em_rec.comp  = comp;
                        em_rec.blk   = 9'(blk_reg);
                        em_rec.done  = (zz_reg == 6'd63);
                        accum_next   = '0;
                        if (zz_reg != 6'd63)
                        begin
                            zz_next = zz_reg + 6'd1;
                        end
                        else
                        begin
                            zz_next    = '0;
                            phase_next = PH_PREFIX;
                            bim_next   = (bim_reg >= 3'd5) ? 3'd0 : bim_reg + 3'd1;
                            blk_next   = blk_reg + BLK_W'(1);
                            if (blk_reg == BLK_W'(TOTAL - 1))
                            begin
                                fin_next     = 1'b1;
                                em_rec.sdone = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (dc_fire)
        begin
            dc_new = dc_sel + DC_WIDTH'(diff);
            dc_z   = 32'(dc_new);
            if (bim_reg < 3'd4)
            begin
                dcy_next = dc_new;
            end
            else if (bim_reg == 3'd4)
            begin
                dcb_next = dc_new;
            end
            else
            begin
                dcr_next = dc_new;
            end
            em           = 1'b1;
            em_rec.value = dc_z[15:0];
            em_rec.pos   = '0;
            em_rec.comp  = comp;
            em_rec.blk   = 9'(blk_reg);
            phase_next   = PH_AC;
            zz_next      = 6'd1;
            left_next    = '0;
            accum_next   = '0;
        end
    end

    always_comb
    begin
        close_rec       = hold_reg;
        close_rec.sdone = hold_reg.sdone | cmd.final_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlow_reg   <= '0;
            qhigh_reg  <= '0;
            div_reg    <= DIVISOR_RESET;
            phase_reg  <= PH_PREFIX;
            prefix_reg <= '0;
            accum_reg  <= '0;
            left_reg   <= '0;
            width_reg  <= '0;
            zz_reg     <= '0;
            bim_reg    <= '0;
            blk_reg    <= '0;
            dcy_reg    <= '0;
            dcb_reg    <= '0;
            dcr_reg    <= '0;
            fin_reg    <= 1'b0;
            hv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_QLOW:    qlow_reg  <= cfg_data;
                    CFG_QHIGH:   qhigh_reg <= cfg_data;
                    CFG_DIVISOR: div_reg   <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.finish && cmd.final_end)
            begin
                phase_reg  <= PH_PREFIX;
                prefix_reg <= '0;
                accum_reg  <= '0;
                left_reg   <= '0;
                width_reg  <= '0;
                zz_reg     <= '0;
                bim_reg    <= '0;
                blk_reg    <= '0;
                dcy_reg    <= '0;
                dcb_reg    <= '0;
                dcr_reg    <= '0;
                fin_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                prefix_reg <= prefix_next;
                accum_reg  <= accum_next;
                left_reg   <= left_next;
                width_reg  <= width_next;
                zz_reg     <= zz_next;
                bim_reg    <= bim_next;
                blk_reg    <= blk_next;
                dcy_reg    <= dcy_next;
                dcb_reg    <= dcb_next;
                dcr_reg    <= dcr_next;
                fin_reg    <= fin_next;
            end
            if (em)
            begin
                hv_reg <= 1'b1;
            end
            else if (cmd.finish && hv_reg)
            begin
                hv_reg <= 1'b0;
            end
            if ((em || cmd.finish) && hv_reg)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
        end
        else if (cmd.step)
        begin
            byte_reg <= {byte_reg[6:0], 1'b0};
        end
        if (em)
        begin
            hold_reg <= em_rec;
            if (hv_reg)
            begin
                outr_reg <= hold_reg;
            end
        end
        else if (cmd.finish && hv_reg)
        begin
            outr_reg <= close_rec;
        end
    end

    always_comb
    begin
        stat.need_div = (phase_reg == PH_AC) && (left_reg == 4'd0) && !fin_reg;
        stat.div_done = ddone;
        stat.pending  = !fin_reg && ((phase_reg == PH_PREFIX) ? (prefix_reg != 3'd0) :
                        ((phase_reg == PH_DCVAL) ? 1'b1 : (left_reg != 4'd0)));
        stat.out_free = out_free;
    end

    assign out_valid = ov_reg;
    assign out_rec   = outr_reg;

endmodule

/* rtl/vwcd_ctrl.sv */
// vwcd_ctrl: sequencer for one byte: load, eight bit steps, width divides, flush, close
// depends on vwcd_pkg
module vwcd_ctrl
    import vwcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     final_byte,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BITS  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       final_reg, final_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        final_next = final_reg;
        cmd        = '0;
        cmd.final_end = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    final_next = final_byte;
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_next = final_reg ? ST_FLUSH : ST_END;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_BITS;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pending)
                begin
                    state_next = ST_END;
                end
                else if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_END:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            final_reg <= final_next;
        end
    end

    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> stat.out_free)
        else $error("bit step issued with result path blocked");

    a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("byte close issued with result path blocked");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide wait");

endmodule

/* rtl/variable_width_coeff_decoder_top.sv */
// variable_width_coeff_decoder_top: dct coefficient bitstream decoder, top level
// depends on vwcd_pkg, vwcd_ctrl, vwcd_dp (and vwcd_div inside it)
//
//  channel   direction  handshake                  payload
//  input     in         in_valid / in_stall        data_byte, final_byte
//  output    out        out_valid / out_stall      coeff_value .. stream_done
//  config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one byte takes a load, a step for each of its bits and a close, plus a serial width
// divide per ac field started, plus flush steps on a final byte
// a full, stalled output register holds the bit parser and the byte close
// reset clears decode state and dc predictors; quant table to 0, divisor to 4
module variable_width_coeff_decoder_top
    import vwcd_pkg::*;
#(
    parameter int MACRO_ROWS = 9,
    parameter int MACRO_COLS = 8,
    parameter int DC_WIDTH   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] coeff_value,
    output logic [5:0]         raster_position,
    output logic [1:0]         component,
    output logic [8:0]         block_number,
    output logic               block_done,
    output logic               stream_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    coef_rec_t rec;

    assign cfg_ready = 1'b1;

    vwcd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .final_byte (final_byte),
        .cmd        (cmd),
        .stat       (stat)
    );

    vwcd_dp #(
        .MACRO_ROWS (MACRO_ROWS),
        .MACRO_COLS (MACRO_COLS),
        .DC_WIDTH   (DC_WIDTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .data_byte (data_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_rec   (rec)
    );

    assign coeff_value     = rec.value;
    assign raster_position = rec.pos;
    assign component       = rec.comp;
    assign block_number    = rec.blk;
    assign block_done      = rec.done;
    assign stream_done     = rec.sdone;

endmodule
